@@ rtl/core/timed_mode_sequencer_core_macros.svh @@
// ----------------------------------------------------------------------------
// timed_mode_sequencer_core_macros.svh
// assertion macros shared by the sequencer rtl
// ----------------------------------------------------------------------------
`ifndef TIMED_MODE_SEQUENCER_CORE_MACROS_SVH
`define TIMED_MODE_SEQUENCER_CORE_MACROS_SVH

// same-cycle implication, disabled while reset is asserted
`define TMS_ASSERT_SAME(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("timed_mode_sequencer_core: same-cycle check failed");

// next-cycle implication, disabled while reset is asserted
`define TMS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("timed_mode_sequencer_core: next-cycle check failed");

`endif

@@ rtl/core/tms_pkg.sv @@
// ----------------------------------------------------------------------------
// tms_pkg
// widths, codes and mode numbers of the timed mode sequencer
// ----------------------------------------------------------------------------
package tms_pkg;

  // field widths
  localparam int unsigned MODE_W      = 4;
  localparam int unsigned DUR_FIELD_W = 16;
  localparam int unsigned REMAIN_W    = 16;
  localparam int unsigned SAMPLES_W   = 16;
  localparam int unsigned CAP_W       = 2;
  localparam int unsigned NEXT_TBL_W  = 52;
  localparam int unsigned CFG_IDX_W   = 3;
  localparam int unsigned CFG_DATA_W  = 64;

  // modes that have a table entry
  localparam int unsigned TBL_MODES = 13;

  // command codes
  localparam logic CMD_TICK  = 1'b0;
  localparam logic CMD_START = 1'b1;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_DUR_0_3   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DUR_4_7   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DUR_8_11  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_DUR_12    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_NEXT_TBL  = 3'd4;

  // modes with entry or exit actions, and the last mode with a table entry
  localparam logic [MODE_W-1:0] MODE_IGNITION  = 4'd0;
  localparam logic [MODE_W-1:0] MODE_MOTOR_L   = 4'd1;
  localparam logic [MODE_W-1:0] MODE_CELL      = 4'd2;
  localparam logic [MODE_W-1:0] MODE_ZERO_ON   = 4'd3;
  localparam logic [MODE_W-1:0] MODE_ZERO_OFF  = 4'd4;
  localparam logic [MODE_W-1:0] MODE_CAL_ON    = 4'd10;
  localparam logic [MODE_W-1:0] MODE_CAL_OFF   = 4'd11;
  localparam logic [MODE_W-1:0] MODE_LAST_TBL  = 4'd12;

  typedef enum logic [CAP_W-1:0] {
    CAP_NONE = 2'd0,
    CAP_CELL = 2'd1,
    CAP_ZERO = 2'd2,
    CAP_CAL  = 2'd3
  } cap_kind_e;

endpackage

@@ rtl/core/tms_if.sv @@
// ----------------------------------------------------------------------------
// tms_if
// valid/ready channels of the sequencer: command words in, status words out
// ----------------------------------------------------------------------------
interface tms_in_if;
  import tms_pkg::*;

  logic              valid;
  logic              ready;
  logic              cmd;
  logic [MODE_W-1:0] start_mode;

  modport source (output valid, output cmd, output start_mode, input ready);
  modport sink   (input valid, input cmd, input start_mode, output ready);
endinterface

interface tms_out_if;
  import tms_pkg::*;

  logic                 valid;
  logic                 ready;
  logic [MODE_W-1:0]    mode;
  logic [REMAIN_W-1:0]  remaining;
  logic                 ignition_on;
  logic                 zero_valve_on;
  logic                 calibration_valve_on;
  logic                 motor_left;
  logic                 motor_right;
  logic [CAP_W-1:0]     capture_kind;
  logic [SAMPLES_W-1:0] capture_samples;

  modport source (
    output valid, output mode, output remaining, output ignition_on,
    output zero_valve_on, output calibration_valve_on, output motor_left,
    output motor_right, output capture_kind, output capture_samples,
    input ready
  );
  modport sink (
    input valid, input mode, input remaining, input ignition_on,
    input zero_valve_on, input calibration_valve_on, input motor_left,
    input motor_right, input capture_kind, input capture_samples,
    output ready
  );
endinterface

@@ rtl/core/timed_mode_sequencer_core.sv @@
// ----------------------------------------------------------------------------
// timed_mode_sequencer_core
// measurement mode sequencer: timed modes with entry and exit pin actions
// ----------------------------------------------------------------------------
// Usage:
//   in_i carries command words: cmd tick decrements the mode counter, cmd
//   start enters start_mode (saturated to the last mode) and loads its
//   duration. Every command word produces exactly one status word on out_o:
//   mode, remaining ticks, the three pin levels, the motor strobes and a
//   capture request with its sample count.
//   Durations and next-mode entries come from the cfg_* write port; write it
//   only while no word is in flight.
//   A word accepted at a clock edge has its status word registered there.
//   Throughput is one word per cycle unless out_o stalls; the mode update is a
//   table select, a decrement and a compare between the state registers.
//   The output register frees in_i.ready whenever it is empty or being read,
//   so a stalled receiver holds one status word and blocks further input.
//   Reset puts the block in mode 0 with a zero count, all pins low and all
//   configuration registers zero; a tick right after reset wraps the count.
// ----------------------------------------------------------------------------
`include "timed_mode_sequencer_core_macros.svh"

module timed_mode_sequencer_core #(
  parameter int unsigned NUM_MODES     = 13,
  parameter int unsigned DURATION_BITS = 16
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [tms_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [tms_pkg::CFG_DATA_W-1:0]     cfg_data_i,
  tms_in_if.sink                             in_i,
  tms_out_if.source                          out_o
);
  import tms_pkg::*;

  localparam logic [MODE_W-1:0] MAX_MODE = MODE_W'(NUM_MODES - 1);

  typedef logic [DURATION_BITS-1:0] cnt_t;

  // configuration registers
  logic [CFG_DATA_W-1:0]  dur_0_3_q, dur_4_7_q, dur_8_11_q;
  logic [DUR_FIELD_W-1:0] dur_12_q;
  logic [NEXT_TBL_W-1:0]  next_tbl_q;

  // sequencer state
  logic [MODE_W-1:0] mode_q, mode_d;
  cnt_t              ticks_q, ticks_d;
  logic              ign_q, ign_d;
  logic              zero_q, zero_d;
  logic              cal_q, cal_d;

  // output register
  logic                 out_valid_q;
  logic [REMAIN_W-1:0]  out_remaining_q;
  logic                 out_ign_q, out_zero_q, out_cal_q;
  logic                 out_mleft_q, out_mright_q;
  logic [MODE_W-1:0]    out_mode_q;
  cap_kind_e            out_kind_q;
  logic [SAMPLES_W-1:0] out_samples_q;

  logic                 in_acc;
  logic                 in_ready;
  cnt_t                 ticks_dec;
  logic                 exiting;
  logic                 entering;
  logic [MODE_W-1:0]    enter_mode;
  logic [DUR_FIELD_W-1:0] cur_dur;
  logic [DUR_FIELD_W-1:0] enter_dur;
  logic                 mleft_d, mright_d;
  cap_kind_e            kind_d;
  logic [SAMPLES_W-1:0] samples_d;

  function automatic logic [DUR_FIELD_W-1:0] dur_sel(
    input logic [MODE_W-1:0]      m,
    input logic [CFG_DATA_W-1:0]  d0,
    input logic [CFG_DATA_W-1:0]  d1,
    input logic [CFG_DATA_W-1:0]  d2,
    input logic [DUR_FIELD_W-1:0] d12
  );
    logic [DUR_FIELD_W-1:0] r;
    case (m[3:2])
      2'd0:    r = d0[{m[1:0], 4'b0000} +: DUR_FIELD_W];
      2'd1:    r = d1[{m[1:0], 4'b0000} +: DUR_FIELD_W];
      2'd2:    r = d2[{m[1:0], 4'b0000} +: DUR_FIELD_W];
      default: r = (m == MODE_LAST_TBL) ? d12 : '0;
    endcase
    return r;
  endfunction

  function automatic logic [MODE_W-1:0] sat_mode(input logic [MODE_W-1:0] m);
    return (m > MAX_MODE) ? MAX_MODE : m;
  endfunction

  function automatic logic [MODE_W-1:0] next_of(
    input logic [MODE_W-1:0]     m,
    input logic [NEXT_TBL_W-1:0] tbl
  );
    logic [MODE_W-1:0] e;
    // modes without a table entry fall back to mode 0
    if (32'(m) < TBL_MODES) begin
      e = tbl[{m, 2'b00} +: MODE_W];
    end else begin
      e = '0;
    end
    return sat_mode(e);
  endfunction

  assign in_ready = !out_valid_q || out_o.ready;
  assign in_acc   = in_i.valid && in_ready;

  always_comb begin
    ticks_dec  = ticks_q - cnt_t'(1);
    exiting    = (in_i.cmd == CMD_TICK) && (ticks_dec == '0);
    entering   = (in_i.cmd == CMD_START) || exiting;
    enter_mode = (in_i.cmd == CMD_START) ? sat_mode(in_i.start_mode)
                                         : next_of(mode_q, next_tbl_q);
    cur_dur    = dur_sel(mode_q, dur_0_3_q, dur_4_7_q, dur_8_11_q, dur_12_q);
    enter_dur  = dur_sel(enter_mode, dur_0_3_q, dur_4_7_q, dur_8_11_q, dur_12_q);

    mode_d    = mode_q;
    ticks_d   = ticks_dec;
    ign_d     = ign_q;
    zero_d    = zero_q;
    cal_d     = cal_q;
    mleft_d   = 1'b0;
    mright_d  = 1'b0;
    kind_d    = CAP_NONE;
    samples_d = '0;

    // exit actions first, so entry actions set the final pin level
    if (exiting) begin
      case (mode_q)
        MODE_IGNITION: ign_d = 1'b0;
        MODE_CELL: begin
          kind_d    = CAP_CELL;
          samples_d = SAMPLES_W'(cnt_t'(cur_dur));
          mright_d  = 1'b1;
        end
        MODE_ZERO_OFF: begin
          kind_d    = CAP_ZERO;
          samples_d = SAMPLES_W'(cnt_t'(cur_dur));
          zero_d    = 1'b0;
        end
        MODE_CAL_OFF: begin
          kind_d    = CAP_CAL;
          samples_d = SAMPLES_W'(cnt_t'(cur_dur));
          cal_d     = 1'b0;
        end
        default: ;
      endcase
    end

    if (entering) begin
      mode_d  = enter_mode;
      ticks_d = cnt_t'(enter_dur);
      case (enter_mode)
        MODE_IGNITION: ign_d   = 1'b1;
        MODE_MOTOR_L:  mleft_d = 1'b1;
        MODE_ZERO_ON:  zero_d  = 1'b1;
        MODE_CAL_ON:   cal_d   = 1'b1;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dur_0_3_q  <= '0;
      dur_4_7_q  <= '0;
      dur_8_11_q <= '0;
      dur_12_q   <= '0;
      next_tbl_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_DUR_0_3:  dur_0_3_q  <= cfg_data_i;
        CFG_DUR_4_7:  dur_4_7_q  <= cfg_data_i;
        CFG_DUR_8_11: dur_8_11_q <= cfg_data_i;
        CFG_DUR_12:   dur_12_q   <= cfg_data_i[DUR_FIELD_W-1:0];
        CFG_NEXT_TBL: next_tbl_q <= cfg_data_i[NEXT_TBL_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= '0;
      ticks_q <= '0;
      ign_q   <= 1'b0;
      zero_q  <= 1'b0;
      cal_q   <= 1'b0;
    end else if (in_acc) begin
      mode_q  <= mode_d;
      ticks_q <= ticks_d;
      ign_q   <= ign_d;
      zero_q  <= zero_d;
      cal_q   <= cal_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_acc) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      out_mode_q      <= mode_d;
      out_remaining_q <= REMAIN_W'(ticks_d);
      out_ign_q       <= ign_d;
      out_zero_q      <= zero_d;
      out_cal_q       <= cal_d;
      out_mleft_q     <= mleft_d;
      out_mright_q    <= mright_d;
      out_kind_q      <= kind_d;
      out_samples_q   <= samples_d;
    end
  end

  assign in_i.ready                 = in_ready;
  assign out_o.valid                = out_valid_q;
  assign out_o.mode                 = out_mode_q;
  assign out_o.remaining            = out_remaining_q;
  assign out_o.ignition_on          = out_ign_q;
  assign out_o.zero_valve_on        = out_zero_q;
  assign out_o.calibration_valve_on = out_cal_q;
  assign out_o.motor_left           = out_mleft_q;
  assign out_o.motor_right          = out_mright_q;
  assign out_o.capture_kind         = out_kind_q;
  assign out_o.capture_samples      = out_samples_q;

  `TMS_ASSERT_SAME(a_mode_in_range, clk_i, rst_ni, 1'b1, mode_q <= MAX_MODE)
  `TMS_ASSERT_SAME(a_stall_blocks_input, clk_i, rst_ni,
                   out_valid_q && !out_o.ready, !in_i.ready)
  `TMS_ASSERT_SAME(a_no_capture_no_samples, clk_i, rst_ni,
                   out_valid_q && (out_kind_q == CAP_NONE), out_samples_q == '0)
  `TMS_ASSERT_SAME(a_motor_right_with_cell, clk_i, rst_ni,
                   out_valid_q && out_mright_q, out_kind_q == CAP_CELL)
  `TMS_ASSERT_NEXT(a_tick_keeps_mode, clk_i, rst_ni,
                   in_acc && (in_i.cmd == CMD_TICK) && (ticks_q != cnt_t'(1)),
                   mode_q == $past(mode_q))

endmodule
